// ----- sv/was_pkg.sv -----
package was_pkg;

  // Table geometry
  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

  // Field widths
  localparam int OP_W       = 3;
  localparam int ENTRY_IX_W = 4;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int SOD_W      = 17;
  localparam int WDAY_W     = 3;
  localparam int MASK_W     = 7;
  localparam int IN_USE_W   = 5;
  localparam int DELAY_W    = 20;
  localparam int TOD_W      = 17;
  localparam int CFG_IX_W   = 2;
  localparam int CFG_DATA_W = 8;

  // Time constants
  localparam int DAY_SECONDS   = 86400;
  localparam int DAYS_PER_WEEK = 7;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_EVAL  = 3'd1,
    OP_FIRED = 3'd2,
    OP_START = 3'd3,
    OP_STOP  = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IX_W-1:0] {
    CFG_REPEAT  = 2'd0,
    CFG_MASK    = 2'd1,
    CFG_ENTRIES = 2'd2
  } cfg_idx_t;

  // One table entry as stored
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              enable;
  } entry_t;

  // Seconds since midnight of an entry's time of day
  function automatic logic [TOD_W-1:0] tod_seconds(entry_t e);
    return TOD_W'(e.hour) * TOD_W'(3600) + TOD_W'(e.minute) * TOD_W'(60)
           + TOD_W'(e.second);
  endfunction

  // First day ahead (1..7) whose mask bit is set, 0 if the mask is empty
  function automatic logic [WDAY_W-1:0] next_day(logic [MASK_W-1:0] mask,
                                                 logic [WDAY_W-1:0] wday);
    logic [WDAY_W-1:0] d_found;
    logic [WDAY_W:0]   pos;
    d_found = '0;
    for (int d = DAYS_PER_WEEK; d >= 1; d--) begin
      pos = (WDAY_W + 1)'(wday) + (WDAY_W + 1)'(d);
      if (pos >= (WDAY_W + 1)'(DAYS_PER_WEEK)) begin
        pos = pos - (WDAY_W + 1)'(DAYS_PER_WEEK);
      end
      if (mask[pos[WDAY_W-1:0]]) begin
        d_found = WDAY_W'(d);
      end
    end
    return d_found;
  endfunction

  // Seconds in a whole number of days ahead
  function automatic logic [DELAY_W-1:0] day_offset(logic [WDAY_W-1:0] d);
    logic [DELAY_W-1:0] ofs;
    case (d)
      3'd1:    ofs = DELAY_W'(1 * DAY_SECONDS);
      3'd2:    ofs = DELAY_W'(2 * DAY_SECONDS);
      3'd3:    ofs = DELAY_W'(3 * DAY_SECONDS);
      3'd4:    ofs = DELAY_W'(4 * DAY_SECONDS);
      3'd5:    ofs = DELAY_W'(5 * DAY_SECONDS);
      3'd6:    ofs = DELAY_W'(6 * DAY_SECONDS);
      3'd7:    ofs = DELAY_W'(7 * DAY_SECONDS);
      default: ofs = '0;
    endcase
    return ofs;
  endfunction

endpackage

// ----- sv/was_in_if.sv -----
interface was_in_if;
  logic                            valid;
  logic                            ready;
  logic [was_pkg::OP_W-1:0]        op;
  logic [was_pkg::ENTRY_IX_W-1:0]  entry_index;
  logic [was_pkg::HOUR_W-1:0]      entry_hour;
  logic [was_pkg::MIN_W-1:0]       entry_minute;
  logic [was_pkg::SEC_W-1:0]       entry_second;
  logic                            entry_enable;
  logic [was_pkg::SOD_W-1:0]       now_second_of_day;
  logic [was_pkg::WDAY_W-1:0]      now_weekday;

  modport source (
    output valid, op, entry_index, entry_hour, entry_minute, entry_second,
           entry_enable, now_second_of_day, now_weekday,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, entry_hour, entry_minute, entry_second,
           entry_enable, now_second_of_day, now_weekday,
    output ready
  );
endinterface

// ----- sv/was_out_if.sv -----
interface was_out_if;
  logic                            valid;
  logic                            ready;
  logic                            armed;
  logic [was_pkg::DELAY_W-1:0]     delay_seconds;
  logic [was_pkg::ENTRY_IX_W-1:0]  next_index;
  logic [was_pkg::ENTRY_IX_W-1:0]  fired_index;

  modport source (
    output valid, armed, delay_seconds, next_index, fired_index,
    input  ready
  );
  modport sink (
    input  valid, armed, delay_seconds, next_index, fired_index,
    output ready
  );
endinterface

// ----- sv/was_cfg_if.sv -----
interface was_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [was_pkg::CFG_IX_W-1:0]     index;
  logic [was_pkg::CFG_DATA_W-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- sv/weekly_alarm_scheduler.sv -----
// Steps: entry write and unused ops go straight to the result word. Evaluate scans the
// N entries in use (N = entries in use) and then loads the result; fired, in one-shot mode
// with a last choice, first does a read-modify-write of the fired entry; start/stop first sweep the N entries.
// One word at a time: the next word is taken only after the result loads, and the result
// load waits while an earlier result is still pending on the output.
// Reset (rst_n low, synchronous): entries read as zero, stopped, no last choice,
// one-shot mode, empty weekday mask, 16 entries in use, no result pending.
module weekly_alarm_scheduler (
  input  logic      clk,
  input  logic      rst_n,
  was_in_if.sink    in_ch,
  was_out_if.source out_ch,
  was_cfg_if.sink   cfg_ch
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SWEEP   = 6'b000010,
    ST_FIRE_RD = 6'b000100,
    ST_FIRE_WR = 6'b001000,
    ST_SCAN    = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  localparam int IDX_W   = was_pkg::IDX_W;
  localparam int CNT_W   = was_pkg::CNT_W;
  localparam int DELAY_W = was_pkg::DELAY_W;
  localparam int SOD_W   = was_pkg::SOD_W;
  localparam int TOD_W   = was_pkg::TOD_W;
  localparam int WDAY_W  = was_pkg::WDAY_W;
  localparam int MASK_W  = was_pkg::MASK_W;
  localparam int EIX_W   = was_pkg::ENTRY_IX_W;

  state_t state_r, state_nxt;

  // Configuration
  logic                          repeat_r;
  logic [MASK_W-1:0]             mask_r;
  logic [was_pkg::IN_USE_W-1:0]  in_use_r;

  // Scheduler state
  logic                running_r;
  logic [IDX_W:0]      last_r;
  logic                sweep_en_r;
  logic [SOD_W-1:0]    now_r;
  logic [DELAY_W-1:0]  day_ofs_r;
  logic                mask_today_r;
  logic [EIX_W-1:0]    fired_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    limit;

  // Entry memory and its valid bits
  was_pkg::entry_t           mem [was_pkg::NUM_ENTRIES];
  logic [was_pkg::NUM_ENTRIES-1:0] valid_r;
  logic                      mem_re, mem_we;
  logic [IDX_W-1:0]          mem_raddr, mem_waddr;
  was_pkg::entry_t           mem_wdata;
  was_pkg::entry_t           rdata_r, entry_q;
  logic                      rd_valid_r;
  logic                      rd_pend_r;
  logic [IDX_W-1:0]          rd_addr_r;

  // Evaluation stage
  logic                t_pend_r;
  logic [TOD_W-1:0]    t_r;
  logic                t_en_r;
  logic [IDX_W-1:0]    t_idx_r;
  logic [DELAY_W-1:0]  best_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic                found_r;
  logic                is_prior, later, cand_ok, take;
  logic [DELAY_W-1:0]  t_ext, cand;

  // Result register
  logic                out_valid_r;
  logic                out_armed_r;
  logic [DELAY_W-1:0]  out_delay_r;
  logic [EIX_W-1:0]    out_next_r;
  logic [EIX_W-1:0]    out_fired_r;

  // Accept-time decode
  logic                in_acc;
  logic                last_ok;
  logic                scan_end;
  logic                out_load;
  logic [SOD_W-1:0]    now_n;
  logic [WDAY_W-1:0]   wday_n;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign last_ok   = (32'(last_r) < was_pkg::NUM_ENTRIES);
  assign limit     = (32'(in_use_r) > was_pkg::NUM_ENTRIES) ? CNT_W'(was_pkg::NUM_ENTRIES)
                                                             : in_use_r[CNT_W-1:0];
  assign now_n     = (32'(in_ch.now_second_of_day) > was_pkg::DAY_SECONDS - 1)
                     ? SOD_W'(was_pkg::DAY_SECONDS - 1) : in_ch.now_second_of_day;
  assign wday_n    = (32'(in_ch.now_weekday) >= was_pkg::DAYS_PER_WEEK)
                     ? '0 : in_ch.now_weekday;
  assign scan_end  = (cnt_r == limit) && !rd_pend_r && !t_pend_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_r <= 1'b0;
      mask_r   <= '0;
      in_use_r <= was_pkg::IN_USE_W'(16);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        was_pkg::CFG_REPEAT:  repeat_r <= cfg_ch.data[0];
        was_pkg::CFG_MASK:    mask_r   <= cfg_ch.data[MASK_W-1:0];
        was_pkg::CFG_ENTRIES: in_use_r <= cfg_ch.data[was_pkg::IN_USE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence the operation
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          case (in_ch.op)
            was_pkg::OP_EVAL:  state_nxt = ST_SCAN;
            was_pkg::OP_FIRED: state_nxt = (last_ok && !repeat_r) ? ST_FIRE_RD : ST_SCAN;
            was_pkg::OP_START: state_nxt = ST_SWEEP;
            was_pkg::OP_STOP:  state_nxt = ST_SWEEP;
            default:           state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (cnt_r != limit) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!rd_pend_r) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_FIRE_RD: state_nxt = ST_FIRE_WR;
      ST_FIRE_WR: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (cnt_r != limit) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Steer the memory ports
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cnt_r[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = rd_addr_r;
    mem_wdata = entry_q;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.op == was_pkg::OP_WRITE
            && 32'(in_ch.entry_index) < was_pkg::NUM_ENTRIES) begin
          mem_we           = 1'b1;
          mem_waddr        = in_ch.entry_index[IDX_W-1:0];
          mem_wdata.hour   = in_ch.entry_hour;
          mem_wdata.minute = in_ch.entry_minute;
          mem_wdata.second = in_ch.entry_second;
          mem_wdata.enable = in_ch.entry_enable;
        end
      end
      ST_SWEEP: begin
        mem_re           = (cnt_r != limit);
        mem_we           = rd_pend_r;
        mem_wdata.enable = sweep_en_r;
      end
      ST_FIRE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = last_r[IDX_W-1:0];
      end
      ST_FIRE_WR: begin
        mem_we           = rd_pend_r;
        mem_wdata.enable = 1'b0;
      end
      ST_SCAN: mem_re = (cnt_r != limit);
      default: ;
    endcase
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r    <= mem[mem_raddr];
      rd_valid_r <= valid_r[mem_raddr];
      rd_addr_r  <= mem_raddr;
    end
  end

  // Unwritten entries read as zero
  assign entry_q = rd_valid_r ? rdata_r : '0;

  // Compare one entry's next trigger against the best so far
  always_comb begin
    is_prior = ({1'b0, t_idx_r} == last_r);
    later    = (t_r > now_r);
    t_ext    = DELAY_W'(t_r);
    if (repeat_r) begin
      cand_ok = (mask_r != '0);
      cand    = (!is_prior && mask_today_r && later) ? t_ext : t_ext + day_ofs_r;
    end else begin
      cand_ok = 1'b1;
      cand    = later ? t_ext : t_ext + DELAY_W'(was_pkg::DAY_SECONDS);
    end
    take = t_pend_r && t_en_r && running_r && cand_ok && (!found_r || cand < best_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      rd_pend_r   <= 1'b0;
      t_pend_r    <= 1'b0;
      found_r     <= 1'b0;
      running_r   <= 1'b0;
      last_r      <= (IDX_W + 1)'(was_pkg::NUM_ENTRIES);
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= mem_re;
      t_pend_r  <= (state_r == ST_SCAN) && rd_pend_r;
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      // start a new word
      if (in_acc) begin
        found_r <= 1'b0;
        if (in_ch.op == was_pkg::OP_START || in_ch.op == was_pkg::OP_STOP) begin
          running_r <= (in_ch.op == was_pkg::OP_START);
          last_r    <= (IDX_W + 1)'(was_pkg::NUM_ENTRIES);
        end
      end else if (take) begin
        found_r <= 1'b1;
      end
      // deliver the result and record the choice
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (found_r) begin
          last_r <= {1'b0, best_idx_r};
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r        <= now_n;
      day_ofs_r    <= was_pkg::day_offset(was_pkg::next_day(mask_r, wday_n));
      mask_today_r <= mask_r[wday_n];
      sweep_en_r   <= (in_ch.op == was_pkg::OP_START);
      fired_r      <= (in_ch.op == was_pkg::OP_FIRED && last_ok)
                      ? EIX_W'(last_r[IDX_W-1:0]) : '0;
    end
    if ((state_r == ST_SCAN) && rd_pend_r) begin
      t_r     <= was_pkg::tod_seconds(entry_q);
      t_en_r  <= entry_q.enable;
      t_idx_r <= rd_addr_r;
    end
    if (take) begin
      best_r     <= cand;
      best_idx_r <= t_idx_r;
    end
    if (out_load) begin
      out_armed_r <= found_r;
      out_delay_r <= found_r ? best_r - DELAY_W'(now_r) : '0;
      out_next_r  <= found_r ? EIX_W'(best_idx_r) : '0;
      out_fired_r <= fired_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.armed         = out_armed_r;
  assign out_ch.delay_seconds = out_delay_r;
  assign out_ch.next_index    = out_next_r;
  assign out_ch.fired_index   = out_fired_r;

  // Read and write never hit the same entry in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("entry read and write collide");

  // An armed trigger always lies in the future
  a_armed_future: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.armed) |-> (out_ch.delay_seconds != '0))
    else $error("armed result with zero delay");

  // The last choice only moves on accept or on result delivery
  a_last_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && !out_load) |=> $stable(last_r))
    else $error("last choice changed mid-operation");

  // The scan leaves the table untouched
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_we)
    else $error("entry written during scan");

endmodule
